// ----- hw/rtl/capsule_capsule_collision_macros.svh -----
// Assertion macros for the capsule collision block.
// Used by the checker; needs nothing else.
`ifndef CAPSULE_CAPSULE_COLLISION_MACROS_SVH
`define CAPSULE_CAPSULE_COLLISION_MACROS_SVH

// Clocked property, disabled while reset is high.
`define CCC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds during reset.
`define CCC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/ccc_pkg.sv -----
// Shared widths, types, codes and helpers of the capsule collision block.
// No dependencies; imported by the divider, the top level and the checker.
`timescale 1ns / 1ps

package ccc_pkg;

   localparam int COORD_W   = 16;
   localparam int POINT_W   = 3 * COORD_W;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int LEN_W     = 36;
   localparam int DOT_W     = LEN_W + 1;
   localparam int SPLIT     = 18;
   localparam int HALF_W    = DOT_W - SPLIT;
   localparam int PP_W      = 2 * HALF_W;
   localparam int WIDE_W    = 76;
   localparam int FRAC_W    = 16;
   localparam int Q_W       = FRAC_W + 1;
   localparam int STEPS     = FRAC_W;
   localparam int THR_W     = 32;
   localparam int SQ_W      = 2 * DIFF_W;
   localparam int DIST_W    = 35;
   localparam int SUM_W     = SQ_W + 2;
   localparam int CSR_ADDR_W = 3;
   localparam int ROUND_HALF = 32768;

   // Pipeline stage numbers: selection, last divider step, output register.
   localparam int ST_SEL = 7;
   localparam int ST_Q   = ST_SEL + STEPS + 1;
   localparam int ST_OUT = ST_Q + 3;

   localparam logic [Q_W-1:0] ONE_Q = Q_W'(1 << FRAC_W);
   localparam logic [0:0] REG_THRESHOLD = 1'b0;

   typedef logic signed [WIDE_W-1:0] wide_type;
   localparam wide_type W_ZERO = '0;
   localparam wide_type W_ONE  = WIDE_W'(1);

   typedef logic [1:0] clamp_type;
   localparam clamp_type CL_IN   = 2'd0;
   localparam clamp_type CL_LOW  = 2'd1;
   localparam clamp_type CL_HIGH = 2'd2;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] a1;
      logic [2:0][COORD_W-1:0] b1;
      logic [2:0][DIFF_W-1:0]  da;
      logic [2:0][DIFF_W-1:0]  db;
      logic [2:0][DIFF_W-1:0]  p;
      logic [DIFF_W-1:0]       rs;
   } geom_type;

   typedef struct packed {
      logic signed [DOT_W-1:0] len_a;
      logic signed [DOT_W-1:0] len_b;
      logic signed [DOT_W-1:0] cr;
      logic signed [DOT_W-1:0] ap;
      logic signed [DOT_W-1:0] bp;
   } dots_type;

   typedef struct packed {
      logic signed [PP_W-1:0] hh;
      logic signed [PP_W-1:0] hl;
      logic signed [PP_W-1:0] lh;
      logic signed [PP_W-1:0] ll;
   } part_type;

   typedef struct packed {
      wide_type den;
      wide_type sn;
      wide_type tn;
      wide_type nt0;
      wide_type nt1;
      wide_type ns0;
      wide_type ns1;
      wide_type ds;
      wide_type dt;
   } nums_type;

   typedef struct packed {
      logic      mvalid;
      clamp_type sc_m;
      clamp_type tc_m;
      clamp_type ct0;
      clamp_type ct1;
      clamp_type cs0;
      clamp_type cs1;
   } codes_type;

   function automatic logic signed [DIFF_W-1:0] sx(input logic [COORD_W-1:0] v);
      return DIFF_W'($signed(v));
   endfunction

endpackage

// ----- hw/rtl/ccc_ratio.sv -----
// Pipelined ratio unit: num/den clamped to [0,1] in Q1.16, one quotient bit a stage.
// Depends on ccc_pkg; accepts a new operand pair every cycle.
`timescale 1ns / 1ps

module ccc_ratio import ccc_pkg::*; (
   input  logic           clock,
   input  wide_type       num,
   input  wide_type       den,
   output logic [Q_W-1:0] q
);

   logic [WIDE_W-1:0] rem_ff [0:STEPS];
   logic [WIDE_W-1:0] den_ff [0:STEPS];
   logic [FRAC_W-1:0] acc_ff [0:STEPS];
   logic              neg_ff [0:STEPS];
   logic              sat_ff [0:STEPS];

   logic neg_in;
   logic sat_in;

   assign neg_in = num < 0;
   assign sat_in = !neg_in && (num >= den);

   always_ff @(posedge clock) begin
      neg_ff[0] <= neg_in;
      sat_ff[0] <= sat_in;
      rem_ff[0] <= (neg_in || sat_in) ? '0 : num;
      den_ff[0] <= den;
      acc_ff[0] <= '0;
   end

   for (genvar g = 1; g <= STEPS; g++) begin : g_step
      logic [WIDE_W-1:0] dbl;
      logic [WIDE_W-1:0] rem_in;
      logic              take;

      always_comb begin
         dbl    = {rem_ff[g-1][WIDE_W-2:0], 1'b0};
         take   = dbl >= den_ff[g-1];
         rem_in = take ? dbl - den_ff[g-1] : dbl;
      end

      always_ff @(posedge clock) begin
         rem_ff[g] <= rem_in;
         den_ff[g] <= den_ff[g-1];
         acc_ff[g] <= {acc_ff[g-1][FRAC_W-2:0], take};
         neg_ff[g] <= neg_ff[g-1];
         sat_ff[g] <= sat_ff[g-1];
      end
   end

   assign q = sat_ff[STEPS] ? ONE_Q : (neg_ff[STEPS] ? '0 : {1'b0, acc_ff[STEPS]});

endmodule

// ----- hw/rtl/capsule_capsule_collision.sv -----
// Capsule-capsule collision test: closest points of two 3D segments, fixed point.
// Depends on ccc_pkg and ccc_ratio. Pipeline: 7 setup stages, 17 stages per ratio
// unit, 3 for the points and distance; each result is strobed on rsp_valid.
// Throughput: one transaction per cycle, set by the fully pipelined ratio units;
// busy stays low and the receiver cannot stall. Synchronous reset clears valid bits
// and sets degenerate_threshold to 1 LSB; in-flight transactions are dropped.
`timescale 1ns / 1ps

module capsule_capsule_collision import ccc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [POINT_W-1:0]    req_seg_a_start,
   input  logic [POINT_W-1:0]    req_seg_a_end,
   input  logic [POINT_W-1:0]    req_seg_b_start,
   input  logic [POINT_W-1:0]    req_seg_b_end,
   input  logic [COORD_W-1:0]    req_radius_a,
   input  logic [COORD_W-1:0]    req_radius_b,
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   output logic [DIST_W-1:0]     rsp_distance_sq,
   output logic [POINT_W-1:0]    rsp_closest_a,
   output logic [POINT_W-1:0]    rsp_closest_b,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [THR_W-1:0]      csr_pwdata,
   output logic [THR_W-1:0]      csr_prdata,
   output logic                  csr_pready
);

   // ---------------------------------------------------------------
   // Configuration: one register, degenerate_threshold (Q16.16).
   // ---------------------------------------------------------------
   logic [THR_W-1:0] thr_ff;
   logic             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == REG_THRESHOLD) ? thr_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(1);
      end else if (csr_wr && (csr_paddr[CSR_ADDR_W-1:2] == REG_THRESHOLD)) begin
         thr_ff <= csr_pwdata;
      end
   end

   // Every stage advances every cycle, so accept on any start.
   logic in_fire;
   assign busy    = 1'b0;
   assign in_fire = start && !busy;

   logic valid_ff [1:ST_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 1; n <= ST_OUT; n++) valid_ff[n] <= 1'b0;
      end else begin
         valid_ff[1] <= in_fire;
         for (int n = 2; n <= ST_OUT; n++) valid_ff[n] <= valid_ff[n-1];
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: unpack, segment directions and start offset.
   // ---------------------------------------------------------------
   geom_type geom_in;
   geom_type geom_ff [1:ST_Q];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         geom_in.a1[k] = req_seg_a_start[COORD_W*k +: COORD_W];
         geom_in.b1[k] = req_seg_b_start[COORD_W*k +: COORD_W];
         geom_in.da[k] = sx(req_seg_a_end[COORD_W*k +: COORD_W])
                       - sx(req_seg_a_start[COORD_W*k +: COORD_W]);
         geom_in.db[k] = sx(req_seg_b_end[COORD_W*k +: COORD_W])
                       - sx(req_seg_b_start[COORD_W*k +: COORD_W]);
         geom_in.p[k]  = sx(req_seg_a_start[COORD_W*k +: COORD_W])
                       - sx(req_seg_b_start[COORD_W*k +: COORD_W]);
      end
      geom_in.rs = {1'b0, req_radius_a} + {1'b0, req_radius_b};
   end

   // Geometry rides a shift line alongside the solve.
   always_ff @(posedge clock) begin
      geom_ff[1] <= geom_in;
      for (int n = 2; n <= ST_Q; n++) geom_ff[n] <= geom_ff[n-1];
   end

   // ---------------------------------------------------------------
   // Stage 2: dot products, exact Q16.16.
   // ---------------------------------------------------------------
   function automatic logic signed [DOT_W-1:0] dot3(
      input logic [2:0][DIFF_W-1:0] u,
      input logic [2:0][DIFF_W-1:0] v
   );
      logic signed [DOT_W-1:0] acc;
      logic signed [SQ_W-1:0]  pr;
      acc = '0;
      for (int k = 0; k < 3; k++) begin
         pr  = $signed(u[k]) * $signed(v[k]);
         acc = acc + DOT_W'(pr);
      end
      return acc;
   endfunction

   dots_type dots_in;
   dots_type dots_ff [2:4];

   always_comb begin
      dots_in.len_a = dot3(geom_ff[1].da, geom_ff[1].da);
      dots_in.len_b = dot3(geom_ff[1].db, geom_ff[1].db);
      dots_in.cr    = dot3(geom_ff[1].da, geom_ff[1].db);
      dots_in.ap    = dot3(geom_ff[1].da, geom_ff[1].p);
      dots_in.bp    = dot3(geom_ff[1].db, geom_ff[1].p);
   end

   always_ff @(posedge clock) begin
      dots_ff[2] <= dots_in;
      dots_ff[3] <= dots_ff[2];
      dots_ff[4] <= dots_ff[3];
   end

   // ---------------------------------------------------------------
   // Stage 3: degenerate flags and partial products of the 2x2 system.
   // Each wide product is split into four half-width products.
   // ---------------------------------------------------------------
   function automatic part_type wsplit(
      input logic signed [DOT_W-1:0] a,
      input logic signed [DOT_W-1:0] b
   );
      logic signed [HALF_W-1:0] ah;
      logic signed [HALF_W-1:0] al;
      logic signed [HALF_W-1:0] bh;
      logic signed [HALF_W-1:0] bl;
      part_type r;
      ah   = $signed(a[DOT_W-1:SPLIT]);
      bh   = $signed(b[DOT_W-1:SPLIT]);
      al   = $signed({1'b0, a[SPLIT-1:0]});
      bl   = $signed({1'b0, b[SPLIT-1:0]});
      r.hh = ah * bh;
      r.hl = ah * bl;
      r.lh = al * bh;
      r.ll = al * bl;
      return r;
   endfunction

   function automatic logic is_degenerate(
      input logic signed [DOT_W-1:0] len,
      input logic [THR_W-1:0]        thr
   );
      return (len == 0) || (len[LEN_W-1:0] < LEN_W'(thr));
   endfunction

   part_type   part_ff [6];
   logic [1:0] deg_ff [3:6];

   always_ff @(posedge clock) begin
      part_ff[0] <= wsplit(dots_ff[2].len_a, dots_ff[2].len_b);
      part_ff[1] <= wsplit(dots_ff[2].cr,    dots_ff[2].cr);
      part_ff[2] <= wsplit(dots_ff[2].cr,    dots_ff[2].bp);
      part_ff[3] <= wsplit(dots_ff[2].ap,    dots_ff[2].len_b);
      part_ff[4] <= wsplit(dots_ff[2].len_a, dots_ff[2].bp);
      part_ff[5] <= wsplit(dots_ff[2].cr,    dots_ff[2].ap);
      deg_ff[3]  <= {is_degenerate(dots_ff[2].len_b, thr_ff),
                     is_degenerate(dots_ff[2].len_a, thr_ff)};
      for (int n = 4; n <= 6; n++) deg_ff[n] <= deg_ff[n-1];
   end

   // ---------------------------------------------------------------
   // Stage 4: join partials into exact Q32.32 products.
   // ---------------------------------------------------------------
   function automatic wide_type wjoin(input part_type pp);
      return (WIDE_W'(pp.hh) <<< (2 * SPLIT))
           + ((WIDE_W'(pp.hl) + WIDE_W'(pp.lh)) <<< SPLIT)
           + WIDE_W'(pp.ll);
   endfunction

   wide_type prod_ff [6];

   always_ff @(posedge clock) begin
      for (int k = 0; k < 6; k++) prod_ff[k] <= wjoin(part_ff[k]);
   end

   // ---------------------------------------------------------------
   // Stage 5: determinant, main numerators and the re-solve numerators.
   // ---------------------------------------------------------------
   nums_type nums_ff [5:6];

   always_ff @(posedge clock) begin
      nums_ff[5].den <= prod_ff[0] - prod_ff[1];
      nums_ff[5].sn  <= prod_ff[2] - prod_ff[3];
      nums_ff[5].tn  <= prod_ff[4] - prod_ff[5];
      nums_ff[5].nt0 <= WIDE_W'(dots_ff[4].bp);
      nums_ff[5].nt1 <= WIDE_W'(dots_ff[4].bp) + WIDE_W'(dots_ff[4].cr);
      nums_ff[5].ns0 <= -WIDE_W'(dots_ff[4].ap);
      nums_ff[5].ns1 <= WIDE_W'(dots_ff[4].cr) - WIDE_W'(dots_ff[4].ap);
      nums_ff[5].ds  <= WIDE_W'(dots_ff[4].len_a);
      nums_ff[5].dt  <= WIDE_W'(dots_ff[4].len_b);
      nums_ff[6]     <= nums_ff[5];
   end

   // ---------------------------------------------------------------
   // Stage 6: clamp direction of every candidate ratio.
   // ---------------------------------------------------------------
   function automatic clamp_type clamp(input wide_type num, input wide_type den);
      if (num < 0) begin
         return CL_LOW;
      end else if (num > den) begin
         return CL_HIGH;
      end
      return CL_IN;
   endfunction

   wide_type  lim;
   codes_type codes_ff;

   assign lim = $signed({{(WIDE_W-THR_W-FRAC_W){1'b0}}, thr_ff, {FRAC_W{1'b0}}});

   always_ff @(posedge clock) begin
      codes_ff.mvalid <= (nums_ff[5].den > 0) && (nums_ff[5].den >= lim);
      codes_ff.sc_m   <= clamp(nums_ff[5].sn,  nums_ff[5].den);
      codes_ff.tc_m   <= clamp(nums_ff[5].tn,  nums_ff[5].den);
      codes_ff.ct0    <= clamp(nums_ff[5].nt0, nums_ff[5].dt);
      codes_ff.ct1    <= clamp(nums_ff[5].nt1, nums_ff[5].dt);
      codes_ff.cs0    <= clamp(nums_ff[5].ns0, nums_ff[5].ds);
      codes_ff.cs1    <= clamp(nums_ff[5].ns1, nums_ff[5].ds);
   end

   // ---------------------------------------------------------------
   // Stage 7: pick the final ratio for s and for t. Clamps only depend
   // on compares, so the whole re-solve chain collapses into one choice.
   // Constant results are fed as 0/1 or 1/1.
   // ---------------------------------------------------------------
   wide_type  s_num_in, s_den_in, t_num_in, t_den_in;
   wide_type  s_num_ff, s_den_ff, t_num_ff, t_den_ff;
   clamp_type sc, tc2, sc2;

   always_comb begin
      s_num_in = W_ZERO;
      s_den_in = W_ONE;
      t_num_in = W_ZERO;
      t_den_in = W_ONE;
      sc  = codes_ff.mvalid ? codes_ff.sc_m : CL_LOW;
      tc2 = (sc == CL_HIGH) ? codes_ff.ct1 : codes_ff.ct0;
      sc2 = (codes_ff.tc_m == CL_HIGH) ? codes_ff.cs1 : codes_ff.cs0;
      case (deg_ff[6])
         2'b11: begin
            // both segments are points: keep start points
         end
         2'b01: begin
            t_num_in = nums_ff[6].nt0;
            t_den_in = nums_ff[6].dt;
         end
         2'b10: begin
            s_num_in = nums_ff[6].ns0;
            s_den_in = nums_ff[6].ds;
         end
         default: begin
            if (sc != CL_IN) begin
               t_num_in = (sc == CL_HIGH) ? nums_ff[6].nt1 : nums_ff[6].nt0;
               t_den_in = nums_ff[6].dt;
               if (tc2 != CL_IN) begin
                  s_num_in = (tc2 == CL_HIGH) ? nums_ff[6].ns1 : nums_ff[6].ns0;
                  s_den_in = nums_ff[6].ds;
               end else begin
                  s_num_in = (sc == CL_HIGH) ? W_ONE : W_ZERO;
               end
            end else if (codes_ff.tc_m != CL_IN) begin
               s_num_in = (codes_ff.tc_m == CL_HIGH) ? nums_ff[6].ns1 : nums_ff[6].ns0;
               s_den_in = nums_ff[6].ds;
               if (sc2 != CL_IN) begin
                  t_num_in = (sc2 == CL_HIGH) ? nums_ff[6].nt1 : nums_ff[6].nt0;
                  t_den_in = nums_ff[6].dt;
               end else begin
                  t_num_in = (codes_ff.tc_m == CL_HIGH) ? W_ONE : W_ZERO;
               end
            end else begin
               s_num_in = nums_ff[6].sn;
               s_den_in = nums_ff[6].den;
               t_num_in = nums_ff[6].tn;
               t_den_in = nums_ff[6].den;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      s_num_ff <= s_num_in;
      s_den_ff <= s_den_in;
      t_num_ff <= t_num_in;
      t_den_ff <= t_den_in;
   end

   // ---------------------------------------------------------------
   // Stages 8..24: two ratio units, one for each segment parameter.
   // ---------------------------------------------------------------
   logic [Q_W-1:0] s_q, t_q;

   ccc_ratio u_ratio_s (
      .clock (clock),
      .num   (s_num_ff),
      .den   (s_den_ff),
      .q     (s_q)
   );

   ccc_ratio u_ratio_t (
      .clock (clock),
      .num   (t_num_ff),
      .den   (t_den_ff),
      .q     (t_q)
   );

   // ---------------------------------------------------------------
   // Stage 25: closest points, start + round(direction * parameter).
   // Rounding halves upward is a floor after adding one half.
   // ---------------------------------------------------------------
   function automatic logic [COORD_W-1:0] lerp1(
      input logic [COORD_W-1:0] p0,
      input logic [DIFF_W-1:0]  d,
      input logic [Q_W-1:0]     f
   );
      logic signed [DIFF_W+Q_W:0]   prod;
      logic signed [DIFF_W+Q_W+1:0] v;
      logic signed [DIFF_W+Q_W+1:0] sh;
      prod = $signed(d) * $signed({1'b0, f});
      v    = (DIFF_W+Q_W+2)'(prod) + (DIFF_W+Q_W+2)'(ROUND_HALF);
      sh   = v >>> FRAC_W;
      return p0 + sh[COORD_W-1:0];
   endfunction

   logic [2:0][COORD_W-1:0] ca_ff [ST_Q+1:ST_Q+2];
   logic [2:0][COORD_W-1:0] cb_ff [ST_Q+1:ST_Q+2];
   logic [DIFF_W-1:0]       rs_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         ca_ff[ST_Q+1][k] <= lerp1(geom_ff[ST_Q].a1[k], geom_ff[ST_Q].da[k], s_q);
         cb_ff[ST_Q+1][k] <= lerp1(geom_ff[ST_Q].b1[k], geom_ff[ST_Q].db[k], t_q);
      end
      rs_ff <= geom_ff[ST_Q].rs;
      ca_ff[ST_Q+2] <= ca_ff[ST_Q+1];
      cb_ff[ST_Q+2] <= cb_ff[ST_Q+1];
   end

   // ---------------------------------------------------------------
   // Stage 26: squared coordinate gaps and squared radius sum.
   // Widen each gap before squaring so the product keeps all its bits.
   // ---------------------------------------------------------------
   logic signed [DIFF_W-1:0] gap [3];
   logic [SQ_W-1:0]          sq_ff [3];
   logic [SQ_W-1:0]          rsum_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         gap[k] = sx(ca_ff[ST_Q+1][k]) - sx(cb_ff[ST_Q+1][k]);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         sq_ff[k] <= $unsigned(SQ_W'(gap[k]) * SQ_W'(gap[k]));
      end
      rsum_ff <= rs_ff * rs_ff;
   end

   // ---------------------------------------------------------------
   // Stage 27: distance sum, hit compare, output register.
   // ---------------------------------------------------------------
   logic [SUM_W-1:0]   dist_sum;
   logic               hit_ff;
   logic [DIST_W-1:0]  dist_ff;
   logic [POINT_W-1:0] ca_out_ff, cb_out_ff;

   assign dist_sum = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);

   always_ff @(posedge clock) begin
      hit_ff    <= dist_sum < SUM_W'(rsum_ff);
      dist_ff   <= dist_sum[DIST_W-1:0];
      ca_out_ff <= ca_ff[ST_Q+2];
      cb_out_ff <= cb_ff[ST_Q+2];
   end

   assign rsp_valid       = valid_ff[ST_OUT];
   assign rsp_hit         = hit_ff;
   assign rsp_distance_sq = dist_ff;
   assign rsp_closest_a   = ca_out_ff;
   assign rsp_closest_b   = cb_out_ff;

endmodule

// ----- hw/rtl/ccc_checker.sv -----
// Port-level checks of the capsule collision block, bound to the top level.
// Depends on ccc_pkg and capsule_capsule_collision_macros.svh.
`timescale 1ns / 1ps
`include "capsule_capsule_collision_macros.svh"

module ccc_checker import ccc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [DIST_W-1:0]  rsp_distance_sq,
   input logic [POINT_W-1:0] rsp_closest_a,
   input logic [POINT_W-1:0] rsp_closest_b
);

   `CCC_ASSERT_ALWAYS(a_reset_flush, clock, reset |=> !rsp_valid, "result after reset")
   `CCC_ASSERT(a_lat_fwd, clock, reset, (start && !busy) |-> ##27 rsp_valid, "lost transaction")
   `CCC_ASSERT(a_lat_back, clock, reset, rsp_valid |-> $past(start && !busy, 27), "extra result")
   `CCC_ASSERT(a_zero_dist, clock, reset, rsp_valid |-> ((rsp_distance_sq == 0) == (rsp_closest_a == rsp_closest_b)), "distance disagrees with points")

endmodule

bind capsule_capsule_collision ccc_checker u_ccc_checker (.*);
